FILE: rtl/sida_pkg.sv
// shared types and constants for the signed integer to decimal text block
// no dependencies; used by the front, queue, back and top modules
package sida_pkg;

   localparam int unsigned VALUE_W     = 32;
   localparam int unsigned CHAR_W      = 8;
   localparam int unsigned MAX_DIGITS  = 10;
   localparam int unsigned DIGIT_IDX_W = 4;
   localparam int unsigned PROD_W      = 64;
   localparam int unsigned RECIP_SHIFT = 35;
   localparam int unsigned QUOT_W      = PROD_W - RECIP_SHIFT;

   localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
   // ceil(2^35 / 10): exact quotient by ten for any 32-bit unsigned value
   localparam logic [VALUE_W-1:0] RECIP_TEN  = 32'hCCCC_CCCD;

   // one classified word waiting for conversion
   typedef struct packed {
      logic               negative;
      logic [VALUE_W-1:0] magnitude;
   } item_type;

   // front to queue
   typedef struct packed {
      logic     push;
      item_type item;
   } push_type;

   // queue to back
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

endpackage

FILE: rtl/sida_front.sv
// front end: accepts input words and splits them into sign and magnitude
// depends on sida_pkg
module sida_front (
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [sida_pkg::VALUE_W-1:0] req_value,
   input  logic                              queue_full,
   output sida_pkg::push_type                push
);

   logic [sida_pkg::VALUE_W-1:0] raw;

   // take a word whenever the queue has room
   assign req_ready = ~queue_full;
   assign raw       = unsigned'(req_value);

   // two's complement magnitude, most negative value wraps to 2^31 unsigned
   always_comb begin
      push.push           = req_valid & ~queue_full;
      push.item.negative  = raw[sida_pkg::VALUE_W-1];
      push.item.magnitude = raw[sida_pkg::VALUE_W-1] ? (~raw + 1'b1) : raw;
   end

endmodule

FILE: rtl/sida_queue.sv
// small fifo of classified words between front and back
// depends on sida_pkg
module sida_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  sida_pkg::push_type push,
   output logic               full,
   output sida_pkg::head_type head,
   input  logic               pop
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   sida_pkg::item_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.item  = mem_ff[rd_ptr_ff];
   assign do_pop     = pop & head.valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push.push) begin
         mem_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

FILE: rtl/sida_back.sv
// back end: divides the magnitude by ten digit by digit and sends the text
// depends on sida_pkg
module sida_back (
   input  logic                          clock,
   input  logic                          reset,
   input  sida_pkg::head_type            head,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [sida_pkg::CHAR_W-1:0]   rsp_char_code,
   output logic                          rsp_is_last
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type                         state_ff, state_in;
   logic                              neg_ff, neg_in;
   logic [sida_pkg::VALUE_W-1:0]      mag_ff, mag_in;
   logic [sida_pkg::PROD_W-1:0]       prod_ff, prod_in;
   logic [3:0]                        digits_ff [sida_pkg::MAX_DIGITS];
   logic [sida_pkg::DIGIT_IDX_W-1:0]  ndig_ff, ndig_in;
   logic [sida_pkg::DIGIT_IDX_W-1:0]  idx_ff, idx_in;
   logic                              sign_pend_ff, sign_pend_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [sida_pkg::CHAR_W-1:0]       rsp_char_ff, rsp_char_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic [sida_pkg::QUOT_W-1:0]       quot;
   logic [sida_pkg::VALUE_W-1:0]      quot_x10;
   logic [sida_pkg::VALUE_W-1:0]      rem;
   logic                              digit_wr;
   logic                              out_free;

   // quotient and remainder from the registered product
   assign quot     = prod_ff[sida_pkg::PROD_W-1:sida_pkg::RECIP_SHIFT];
   assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
   assign rem      = mag_ff - quot_x10;
   assign out_free = ~rsp_valid_ff | rsp_ready;
   assign pop      = (state_ff == ST_IDLE) & head.valid;
   assign digit_wr = (state_ff == ST_DIV);

   // conversion and emit sequencer
   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      prod_in      = prod_ff;
      ndig_in      = ndig_ff;
      idx_in       = idx_ff;
      sign_pend_in = sign_pend_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               neg_in   = head.item.negative;
               mag_in   = head.item.magnitude;
               ndig_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = mag_ff * sida_pkg::RECIP_TEN;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            mag_in  = {{(sida_pkg::VALUE_W - sida_pkg::QUOT_W){1'b0}}, quot};
            ndig_in = ndig_ff + 1'b1;
            if (quot == '0) begin
               sign_pend_in = neg_ff;
               idx_in       = ndig_ff;
               state_in     = ST_EMIT;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (sign_pend_ff) begin
                  rsp_char_in  = sida_pkg::CHAR_MINUS;
                  rsp_last_in  = 1'b0;
                  sign_pend_in = 1'b0;
               end else begin
                  rsp_char_in = sida_pkg::CHAR_ZERO + {4'b0000, digits_ff[idx_ff]};
                  rsp_last_in = (idx_ff == '0);
                  if (idx_ff == '0) begin
                     state_in = ST_IDLE;
                  end else begin
                     idx_in = idx_ff - 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sign_pend_ff <= 1'b0;
         ndig_ff      <= '0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sign_pend_ff <= sign_pend_in;
         ndig_ff      <= ndig_in;
         idx_ff       <= idx_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      prod_ff     <= prod_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      if (digit_wr) begin
         digits_ff[ndig_ff] <= rem[3:0];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_is_last   = rsp_last_ff;

   // a divide step always follows a multiply
   a_div_after_mul: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> $past(state_ff) == ST_MUL)
      else $error("divide step without product");

   // remainder of the reciprocal divide is a single decimal digit
   a_rem_digit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem < 32'd10)
      else $error("remainder out of range");

   // emit index stays inside the collected digits
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> idx_ff < ndig_ff && ndig_ff <= 4'd10)
      else $error("emit index beyond digit count");

   // only a minus sign or a digit goes out
   a_char_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_char_ff == sida_pkg::CHAR_MINUS ||
                       (rsp_char_ff >= sida_pkg::CHAR_ZERO &&
                        rsp_char_ff <= sida_pkg::CHAR_ZERO + 8'd9))
      else $error("illegal character code");

   // a minus sign is never the end of a word's text
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_char_ff == sida_pkg::CHAR_MINUS |-> !rsp_last_ff)
      else $error("minus sign marked last");

endmodule

FILE: rtl/signed_int_to_decimal_ascii_top.sv
// top level of the signed 32-bit integer to decimal text converter
// depends on sida_pkg, sida_front, sida_queue and sida_back
//
// usage:
//   req channel (req_valid, req_ready, req_value) takes one signed 32-bit
//   word. rsp channel (rsp_valid, rsp_ready, rsp_char_code, rsp_is_last)
//   returns its decimal text one character per beat, most significant digit
//   first, with a leading '-' for negative values; rsp_is_last marks the
//   final character. zero gives a single '0'.
//   the front splits sign and magnitude and parks the word in a small queue
//   (QUEUE_DEPTH entries), so inputs keep flowing while the back works.
//   the back divides by ten with a reciprocal multiply, a multiply step and
//   then a quotient and remainder step per digit, then sends the characters.
//   it takes the next word from the queue only once it has issued the last
//   character of the current one.
//   reset empties the queue and the output register and idles the back.
//   when the receiver stalls the current character holds in the output
//   register and the back waits, then the queue fills and req_ready drops.
module signed_int_to_decimal_ascii_top #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [sida_pkg::VALUE_W-1:0]  req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [sida_pkg::CHAR_W-1:0]          rsp_char_code,
   output logic                                 rsp_is_last
);

   sida_pkg::push_type push;
   sida_pkg::head_type head;
   logic               queue_full;
   logic               pop;

   // classify incoming words
   sida_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .queue_full (queue_full),
      .push       (push)
   );

   // decouple front and back
   sida_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   // digit conversion and character output
   sida_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_is_last   (rsp_is_last)
   );

endmodule

FILE: tb/signed_int_to_decimal_ascii_top_test.sv
// testbench for signed_int_to_decimal_ascii_top: checks the decimal text of signed words
// depends on sida_pkg and the rtl of signed_int_to_decimal_ascii_top
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_top_test;

   localparam int unsigned RESET_CYCLES = 10;
   localparam int unsigned DRAIN_CYCLES = 64;
   localparam int unsigned CYCLE_LIMIT  = 200000;

   // one word waiting to go out, or a hold point that waits for the text to drain
   typedef struct {
      logic                         hold;
      logic [sida_pkg::VALUE_W-1:0] value;
   } pending_word_type;

   // one character of expected text
   typedef struct {
      logic [sida_pkg::CHAR_W-1:0] code;
      logic                        last;
   } text_char_type;

   // receiver stall patterns
   typedef enum logic [1:0] {
      READY_STEADY,
      READY_COIN,
      READY_LONG_STALLS
   } ready_mode_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [sida_pkg::VALUE_W-1:0] req_value = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [sida_pkg::CHAR_W-1:0]  rsp_char_code;
   logic                         rsp_is_last;

   pending_word_type pending_words[$];
   text_char_type    expected_text[$];
   int unsigned      error_count = 0;
   int unsigned      cycle_count = 0;

   signed_int_to_decimal_ascii_top u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_is_last   (rsp_is_last)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // decimal text of one word, sign first, most significant digit first
   function automatic void predict_decimal_text(logic [sida_pkg::VALUE_W-1:0] word);
      logic [sida_pkg::VALUE_W-1:0] mag;
      logic [sida_pkg::CHAR_W-1:0]  digits[sida_pkg::MAX_DIGITS];
      int                           n;
      logic                         negative;
      negative = word[sida_pkg::VALUE_W-1];
      mag      = negative ? (~word + 1'b1) : word;
      n        = 0;
      do begin
         digits[n] = sida_pkg::CHAR_ZERO + sida_pkg::CHAR_W'(mag % 10);
         mag       = mag / 10;
         n++;
      end while (mag != 0 && n < sida_pkg::MAX_DIGITS);
      if (negative)
         expected_text.push_back('{sida_pkg::CHAR_MINUS, 1'b0});
      for (int k = n - 1; k >= 0; k--)
         expected_text.push_back('{digits[k], (k == 0)});
   endfunction

   function automatic void add_word(logic [sida_pkg::VALUE_W-1:0] v);
      pending_words.push_back('{1'b0, v});
   endfunction

   function automatic void add_hold();
      pending_words.push_back('{1'b1, '0});
   endfunction

   // random word: mostly a chosen number of digits and a random sign, else any bits
   function automatic logic [sida_pkg::VALUE_W-1:0] random_word();
      int unsigned                  ndig;
      logic [sida_pkg::VALUE_W-1:0] lo;
      logic [sida_pkg::VALUE_W-1:0] hi;
      logic [sida_pkg::VALUE_W-1:0] mag;
      logic                         negative;
      if ($urandom_range(99, 0) < 15)
         return $urandom();
      ndig     = $urandom_range(sida_pkg::MAX_DIGITS, 1);
      negative = 1'($urandom_range(1, 0));
      lo       = 1;
      for (int i = 1; i < ndig; i++)
         lo = lo * 10;
      if (ndig == 1)
         lo = 0;
      if (ndig == sida_pkg::MAX_DIGITS)
         hi = negative ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else
         hi = (lo == 0) ? 32'd9 : lo * 10 - 1;
      mag = $urandom_range(hi, lo);
      return negative ? (~mag + 1'b1) : mag;
   endfunction

   // sender: bursts of words separated by random gaps, plus hold points
   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;

   always @(posedge clock) begin
      pending_word_type next_word;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            predict_decimal_text(req_value);
         if (req_valid && !req_ready) begin
            // word still waiting, hold it
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_words.size() == 0) begin
            req_valid <= 1'b0;
         end else if (pending_words[0].hold) begin
            req_valid <= 1'b0;
            if (expected_text.size() == 0 && !(req_valid && req_ready))
               void'(pending_words.pop_front());
         end else begin
            next_word = pending_words.pop_front();
            req_value <= next_word.value;
            req_valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(30, 0);
               case ($urandom_range(3, 0))
                  0:       gap_left = 0;
                  1:       gap_left = $urandom_range(40, 10);
                  default: gap_left = $urandom_range(8, 1);
               endcase
            end
         end
      end
   end

   // receiver: stall pattern that switches between a few modes
   ready_mode_type ready_mode = READY_STEADY;
   int unsigned    mode_left  = 0;
   int unsigned    hold_left  = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(2, 0));
            mode_left  = $urandom_range(300, 40);
            hold_left  = 0;
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
         end else begin
            case (ready_mode)
               READY_STEADY: begin
                  rsp_ready <= 1'b1;
                  hold_left = $urandom_range(40, 1);
               end
               READY_COIN: begin
                  rsp_ready <= 1'($urandom_range(1, 0));
                  hold_left = 0;
               end
               default: begin
                  rsp_ready <= !rsp_ready;
                  hold_left = rsp_ready ? $urandom_range(20, 1) : $urandom_range(6, 1);
               end
            endcase
         end
      end
   end

   // monitor: each accepted character against the oldest expected one
   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_text.size() == 0) begin
            $error("unexpected word: char_code %0d is_last %0b", rsp_char_code, rsp_is_last);
            error_count++;
         end else begin
            want = expected_text.pop_front();
            if (rsp_char_code !== want.code) begin
               $error("char_code mismatch: expected %0d actual %0d", want.code, rsp_char_code);
               error_count++;
            end
            if (rsp_is_last !== want.last) begin
               $error("is_last mismatch: expected %0b actual %0b", want.last, rsp_is_last);
               error_count++;
            end
         end
      end
   end

   // stimulus, reset and end of run
   initial begin
      // directed: zero, one digit, digit count edges, both extremes, bit patterns
      add_word(32'd0);
      add_word(32'd1);
      add_word(32'hFFFF_FFFF);
      add_word(32'd9);
      add_word(32'd10);
      add_word(-32'sd10);
      add_word(32'd99);
      add_word(32'd100);
      add_word(32'h7FFF_FFFF);
      add_word(32'h8000_0000);
      add_word(32'h8000_0001);
      add_word(32'd1000000000);
      add_word(32'd999999999);
      add_word(-32'sd999999999);
      add_word(32'd1234567890);
      add_word(-32'sd1234567890);
      add_word(32'h5555_5555);
      add_word(32'hAAAA_AAAA);
      add_word(-32'sd9);
      add_word(32'd1000000001);
      add_hold();
      add_word(32'h8000_0000);
      add_word(32'd0);
      add_word(32'h7FFF_FFFF);

      // random words, one hold point partway
      for (int i = 0; i < 76; i++) begin
         if (i == 38)
            add_hold();
         add_word(random_word());
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending_words.size() != 0 || req_valid || expected_text.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_text.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         if (expected_text.size() != 0)
            $error("%0d expected characters never arrived", expected_text.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

endmodule
